/* src/nlcf_pkg.sv */
package nlcf_pkg;

  // Field widths
  localparam int VERTEX_W = 20;
  localparam int DEGREE_W = 16;
  localparam int LABEL_W  = 6;
  localparam int COUNT_W  = 16;

  // Default size of the label table
  localparam int NUM_LABELS_DEF = 64;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_BEGIN = 2'd2,
    ACT_ENTRY = 2'd3
  } action_t;

  // One input word after unpacking
  typedef struct packed {
    action_t              action;
    logic [VERTEX_W-1:0]  vertex_id;
    logic [DEGREE_W-1:0]  vertex_degree;
    logic [LABEL_W-1:0]   label;
    logic [COUNT_W-1:0]   label_count;
    logic                 last;
  } item_t;

  // Judgment handed from the core to the output register
  typedef struct packed {
    logic                 fire;
    logic [VERTEX_W-1:0]  vertex;
    logic                 ok;
  } result_t;

  // Register map
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int REG_QUERY_DEG = 0;

  // A label addresses the table only below the table size
  function automatic logic label_in_range(input logic [LABEL_W-1:0] lbl, input int depth);
    return int'(lbl) < depth;
  endfunction

endpackage

/* src/nlcf_ram.sv */
module nlcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/nlcf_core.sv */
module nlcf_core #(
  parameter int NUM_LABELS = nlcf_pkg::NUM_LABELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  nlcf_pkg::item_t               item,
  input  logic [nlcf_pkg::COUNT_W-1:0]  need_count,
  input  logic [nlcf_pkg::DEGREE_W-1:0] query_degree,
  output nlcf_pkg::result_t             res
);

  localparam int IDX_W = $clog2(NUM_LABELS);

  logic [NUM_LABELS-1:0]          needed_mask, needed_mask_next;
  logic [NUM_LABELS-1:0]          met_mask, met_mask_next;
  logic [nlcf_pkg::VERTEX_W-1:0]  current_vertex, current_vertex_next;
  logic                           degree_ok, degree_ok_next;
  logic [IDX_W-1:0]               idx;
  logic                           in_range;
  logic [NUM_LABELS-1:0]          label_bit;

  assign idx       = IDX_W'(item.label);
  assign in_range  = nlcf_pkg::label_in_range(item.label, NUM_LABELS);
  // Labels past the table may alias in idx, so every use of label_bit is gated by in_range
  assign label_bit = {{(NUM_LABELS-1){1'b0}}, 1'b1} << idx;

  // Next state for the word in the input register
  always_comb begin
    needed_mask_next    = needed_mask;
    met_mask_next       = met_mask;
    current_vertex_next = current_vertex;
    degree_ok_next      = degree_ok;
    unique case (item.action)
      nlcf_pkg::ACT_CLEAR: begin
        needed_mask_next = '0;
      end
      nlcf_pkg::ACT_LOAD: begin
        // a zero need is always met, so it drops the label
        if (in_range) begin
          if (item.label_count != '0) begin
            needed_mask_next = needed_mask | label_bit;
          end else begin
            needed_mask_next = needed_mask & ~label_bit;
          end
        end
      end
      nlcf_pkg::ACT_BEGIN: begin
        current_vertex_next = item.vertex_id;
        degree_ok_next      = item.vertex_degree >= query_degree;
        met_mask_next       = '0;
      end
      nlcf_pkg::ACT_ENTRY: begin
        if (in_range && (|(needed_mask & label_bit)) && item.label_count >= need_count) begin
          met_mask_next = met_mask | label_bit;
        end
      end
      default: begin
      end
    endcase
  end

  // Judge on the closing word of a vertex
  always_comb begin
    res.fire   = item.last &&
                 (item.action == nlcf_pkg::ACT_BEGIN || item.action == nlcf_pkg::ACT_ENTRY);
    res.vertex = current_vertex_next;
    res.ok     = degree_ok_next && !(|(needed_mask & ~met_mask_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needed_mask    <= '0;
      met_mask       <= '0;
      current_vertex <= '0;
      degree_ok      <= 1'b0;
    end else if (step) begin
      needed_mask    <= needed_mask_next;
      met_mask       <= met_mask_next;
      current_vertex <= current_vertex_next;
      degree_ok      <= degree_ok_next;
    end
  end

endmodule

/* src/neighbor_label_count_filter.sv */
// A closing word goes from the input register to the output register, which raises m_tvalid.
// Throughput: one input word per cycle; the input stalls only while a result waits
// in the output register and the word in the input register carries one of its own.
// The need table is read once per accepted word; its registered read sets the
// input register stage, and the judgment sits between that and the output register.
// Reset (rst, synchronous) clears needs, the current vertex and query_degree;
// need counts stay undefined until loaded.
module neighbor_label_count_filter #(
  parameter int NUM_LABELS = nlcf_pkg::NUM_LABELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input words
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,  // vertex_id[19:0], vertex_degree[35:20],
                                                    // label[41:36], label_count[57:42], 0
  input  logic [1:0]                      s_tuser,  // action[1:0]
  input  logic                            s_tlast,  // last
  // result words
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,  // candidate_vertex[19:0], accepted[20], 0
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nlcf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nlcf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nlcf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int IDX_W = $clog2(NUM_LABELS);

  nlcf_pkg::item_t                in_item, s1_item;
  logic                           s1_valid;
  logic                           in_accept, s1_adv, out_free;
  logic [nlcf_pkg::DEGREE_W-1:0]  query_degree;
  logic [nlcf_pkg::COUNT_W-1:0]   need_count;
  logic                           need_we;
  nlcf_pkg::result_t              res;
  logic                           cfg_sel;

  // Unpack the input word
  always_comb begin
    in_item.action        = nlcf_pkg::action_t'(s_tuser);
    in_item.vertex_id     = s_tdata[19:0];
    in_item.vertex_degree = s_tdata[35:20];
    in_item.label         = s_tdata[41:36];
    in_item.label_count   = s_tdata[57:42];
    in_item.last          = s_tlast;
  end

  // Handshake: the input register moves on unless its result cannot be placed
  assign out_free  = !m_tvalid || m_tready;
  assign s1_adv    = s1_valid && (!res.fire || out_free);
  assign s_tready  = !s1_valid || s1_adv;
  assign in_accept = s_tvalid && s_tready;

  // Need table: written and read as words are accepted, so reads see every earlier load
  assign need_we = in_accept && in_item.action == nlcf_pkg::ACT_LOAD &&
                   nlcf_pkg::label_in_range(in_item.label, NUM_LABELS);

  nlcf_ram #(
    .WIDTH (nlcf_pkg::COUNT_W),
    .DEPTH (NUM_LABELS)
  ) u_need_ram (
    .clk   (clk),
    .we    (need_we),
    .waddr (IDX_W'(in_item.label)),
    .wdata (in_item.label_count),
    .re    (in_accept),
    .raddr (IDX_W'(in_item.label)),
    .rdata (need_count)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (in_accept) begin
      s1_item <= in_item;
    end
  end

  nlcf_core #(
    .NUM_LABELS (NUM_LABELS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_adv),
    .item         (s1_item),
    .need_count   (need_count),
    .query_degree (query_degree),
    .res          (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_adv && res.fire;
    end
    if (out_free && s1_adv && res.fire) begin
      m_tdata <= {3'b000, res.ok, res.vertex};
    end
  end

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_sel = paddr[2] == 1'(nlcf_pkg::REG_QUERY_DEG);

  always_ff @(posedge clk) begin
    if (rst) begin
      query_degree <= '0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      query_degree <= pwdata[nlcf_pkg::DEGREE_W-1:0];
    end
  end

  assign prdata = cfg_sel ? nlcf_pkg::CFG_DATA_W'(query_degree) : '0;

endmodule

/* bench/neighbor_label_count_filter_tb.sv */
`timescale 1ns / 1ps

module neighbor_label_count_filter_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int NPHASE      = 6;
  localparam int PHASE_WORDS = 145;

  // One judged vertex as the block reports it
  typedef struct packed {
    logic [nlcf_pkg::VERTEX_W-1:0] vertex;
    logic                          ok;
  } verdict_t;

  // Tracks needs, the open vertex and the verdicts still owed by the block
  class label_filter_scoreboard;
    logic [nlcf_pkg::COUNT_W-1:0]  need_cnt [nlcf_pkg::NUM_LABELS_DEF];
    logic [63:0]                   need_mask = '0;
    logic [63:0]                   met_mask = '0;
    logic [nlcf_pkg::VERTEX_W-1:0] cur_vertex = '0;
    logic                          deg_ok = 1'b0;
    logic [nlcf_pkg::DEGREE_W-1:0] query_deg = '0;
    verdict_t                      pending[$];
    int                            errors = 0;
    int                            verdicts = 0;
    int                            accepts = 0;

    function void set_query_degree(logic [nlcf_pkg::DEGREE_W-1:0] v);
      query_deg = v;
    endfunction

    // Every 6-bit label lies inside the 64-entry table
    function void note_input(nlcf_pkg::item_t w);
      verdict_t v;
      case (w.action)
        nlcf_pkg::ACT_CLEAR: need_mask = '0;
        nlcf_pkg::ACT_LOAD: begin
          need_cnt[w.label]  = w.label_count;
          need_mask[w.label] = (w.label_count != '0);
        end
        nlcf_pkg::ACT_BEGIN: begin
          cur_vertex = w.vertex_id;
          deg_ok     = (w.vertex_degree >= query_deg);
          met_mask   = '0;
        end
        nlcf_pkg::ACT_ENTRY: begin
          if (need_mask[w.label] && w.label_count >= need_cnt[w.label])
            met_mask[w.label] = 1'b1;
        end
      endcase
      if (w.last && (w.action == nlcf_pkg::ACT_BEGIN || w.action == nlcf_pkg::ACT_ENTRY)) begin
        v.vertex = cur_vertex;
        v.ok     = deg_ok && ((need_mask & ~met_mask) == '0);
        pending  = {pending, v};
      end
    endfunction

    function void check_result(logic [nlcf_pkg::VERTEX_W-1:0] vertex, logic ok);
      verdict_t e;
      if (pending.size() == 0) begin
        $error("verdict for vertex %0d (accepted %0d) with none expected", vertex, ok);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (vertex !== e.vertex) begin
        $error("candidate_vertex: expected %0d, got %0d", e.vertex, vertex);
        errors++;
      end
      if (ok !== e.ok) begin
        $error("accepted: expected %0d, got %0d", e.ok, ok);
        errors++;
      end
      verdicts++;
      if (e.ok) accepts++;
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [63:0]                     s_tdata;
  logic [1:0]                      s_tuser;
  logic                            s_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [23:0]                     m_tdata;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [nlcf_pkg::CFG_ADDR_W-1:0] paddr;
  logic [nlcf_pkg::CFG_DATA_W-1:0] pwdata;
  logic [nlcf_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  label_filter_scoreboard sb;
  bit                     tx_idle;
  bit                     rx_idle;
  int                     words_sent = 0;
  int                     quiet_cycles = 0;

  // Needs the stimulus believes are loaded, used to aim entries at them
  logic [nlcf_pkg::LABEL_W-1:0] pool_lbl[$];
  logic [nlcf_pkg::COUNT_W-1:0] pool_cnt[$];

  neighbor_label_count_filter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Word builders; fields the action does not use get random values
  function automatic nlcf_pkg::item_t rand_word(nlcf_pkg::action_t act, logic lst);
    nlcf_pkg::item_t w;
    w.action        = act;
    w.vertex_id     = nlcf_pkg::VERTEX_W'($urandom);
    w.vertex_degree = nlcf_pkg::DEGREE_W'($urandom);
    w.label         = nlcf_pkg::LABEL_W'($urandom);
    w.label_count   = nlcf_pkg::COUNT_W'($urandom);
    w.last          = lst;
    return w;
  endfunction

  function automatic nlcf_pkg::item_t label_word(nlcf_pkg::action_t act,
                                                 logic [nlcf_pkg::LABEL_W-1:0] lbl,
                                                 logic [nlcf_pkg::COUNT_W-1:0] cnt,
                                                 logic lst);
    nlcf_pkg::item_t w;
    w             = rand_word(act, lst);
    w.label       = lbl;
    w.label_count = cnt;
    return w;
  endfunction

  function automatic nlcf_pkg::item_t begin_word(logic [nlcf_pkg::VERTEX_W-1:0] vid,
                                                 logic [nlcf_pkg::DEGREE_W-1:0] deg,
                                                 logic lst);
    nlcf_pkg::item_t w;
    w               = rand_word(nlcf_pkg::ACT_BEGIN, lst);
    w.vertex_id     = vid;
    w.vertex_degree = deg;
    return w;
  endfunction

  // Value one below, at or one above c, clamped to 16 bits
  function automatic logic [15:0] near16(logic [15:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Present one word and hold it until the block takes it
  task automatic send_word(nlcf_pkg::item_t w);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, w.label_count, w.label, w.vertex_degree, w.vertex_id};
    s_tuser  <= w.action;
    s_tlast  <= w.last;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_input(w);
    words_sent++;
  endtask

  task automatic load_need(logic [nlcf_pkg::LABEL_W-1:0] lbl,
                           logic [nlcf_pkg::COUNT_W-1:0] cnt, logic lst);
    send_word(label_word(nlcf_pkg::ACT_LOAD, lbl, cnt, lst));
    if (cnt != '0) begin
      pool_lbl = {pool_lbl, lbl};
      pool_cnt = {pool_cnt, cnt};
    end
  endtask

  task automatic clear_needs(logic lst);
    send_word(rand_word(nlcf_pkg::ACT_CLEAR, lst));
    pool_lbl.delete();
    pool_cnt.delete();
  endtask

  // Entry aimed at a known need most of the time, else fully random
  task automatic send_entry(logic lst);
    int i;
    if (pool_lbl.size() != 0 && $urandom_range(0, 3) != 0) begin
      i = $urandom_range(0, pool_lbl.size() - 1);
      send_word(label_word(nlcf_pkg::ACT_ENTRY, pool_lbl[i], near16(pool_cnt[i]), lst));
    end else begin
      send_word(label_word(nlcf_pkg::ACT_ENTRY, nlcf_pkg::LABEL_W'($urandom),
                           nlcf_pkg::COUNT_W'($urandom), lst));
    end
  endtask

  // Well-formed vertex: begin, entries, last on the closing word
  task automatic send_vertex();
    int                            n;
    int                            k;
    bit                            cover_all;
    logic [nlcf_pkg::DEGREE_W-1:0] deg;
    cover_all = $urandom_range(0, 1);
    n = cover_all ? pool_lbl.size() + $urandom_range(0, 2) : $urandom_range(0, 6);
    deg = ($urandom_range(0, 3) == 0) ? nlcf_pkg::DEGREE_W'($urandom) : near16(sb.query_deg);
    send_word(begin_word(nlcf_pkg::VERTEX_W'($urandom), deg, n == 0));
    for (k = 0; k < n; k++) begin
      // occasional need change in the middle of a vertex
      if ($urandom_range(0, 11) == 0)
        load_need(nlcf_pkg::LABEL_W'($urandom), nlcf_pkg::COUNT_W'($urandom_range(0, 20)),
                  1'b0);
      if (cover_all && k < pool_lbl.size())
        send_word(label_word(nlcf_pkg::ACT_ENTRY, pool_lbl[k], near16(pool_cnt[k]),
                             k == n - 1));
      else
        send_entry(k == n - 1);
    end
  endtask

  // Stray and broken traffic
  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: clear_needs(1'($urandom));
      1: load_need(nlcf_pkg::LABEL_W'($urandom),
                   ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 30)),
                   1'($urandom));
      2: send_entry(1'($urandom));
      3: send_word(begin_word(nlcf_pkg::VERTEX_W'($urandom), nlcf_pkg::DEGREE_W'($urandom),
                              1'b0));
      default: send_word(rand_word(nlcf_pkg::action_t'($urandom_range(0, 3)), 1'($urandom)));
    endcase
  endtask

  // Hold off until every verdict is in and the pipeline has emptied
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_query_degree(logic [nlcf_pkg::DEGREE_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= nlcf_pkg::CFG_ADDR_W'(4 * nlcf_pkg::REG_QUERY_DEG);
    pwdata  <= nlcf_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_query_degree(v);
  endtask

  // Short hand-picked sequence, query degree still at its reset value
  task automatic run_directed();
    // entry with no begin after reset: vertex 0, degree not met
    send_word(label_word(nlcf_pkg::ACT_ENTRY, 6'd17, nlcf_pkg::COUNT_W'($urandom), 1'b1));
    // last on clear and load is ignored
    clear_needs(1'b1);
    load_need(6'd0, 16'hFFFF, 1'b1);
    load_need(6'd63, 16'd1, 1'b0);
    send_word(begin_word(20'hFFFFF, 16'hFFFF, 1'b0));
    send_word(label_word(nlcf_pkg::ACT_ENTRY, 6'd0, 16'hFFFF, 1'b0));
    send_word(label_word(nlcf_pkg::ACT_ENTRY, 6'd63, 16'd0, 1'b0));
    // repeated label: second entry meets the need
    send_word(label_word(nlcf_pkg::ACT_ENTRY, 6'd63, 16'd1, 1'b1));
    // further entry re-judges the same vertex
    send_word(label_word(nlcf_pkg::ACT_ENTRY, 6'd5, 16'd7, 1'b1));
    // begin with last, needs unmet
    send_word(begin_word(20'd0, 16'd0, 1'b1));
    clear_needs(1'b0);
    send_word(begin_word(20'd3, 16'd0, 1'b1));
    // need of zero drops the label
    load_need(6'd10, 16'hFFFF, 1'b0);
    load_need(6'd10, 16'd0, 1'b0);
    send_word(begin_word(20'd4, 16'h8000, 1'b1));
    // need loaded after its entry went by
    send_word(begin_word(20'd9, 16'd100, 1'b0));
    send_word(label_word(nlcf_pkg::ACT_ENTRY, 6'd10, 16'd5, 1'b0));
    load_need(6'd10, 16'd5, 1'b0);
    send_word(label_word(nlcf_pkg::ACT_ENTRY, 6'd20, 16'd1, 1'b1));
    send_word(label_word(nlcf_pkg::ACT_ENTRY, 6'd10, 16'd5, 1'b1));
    send_word(label_word(nlcf_pkg::ACT_ENTRY, 6'd10, 16'd4, 1'b1));
    clear_needs(1'b1);
  endtask

  // Result side: random stalls, check every accepted word
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_result(m_tdata[nlcf_pkg::VERTEX_W-1:0], m_tdata[nlcf_pkg::VERTEX_W]);
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int                            ph;
    int                            k;
    int                            phase_start;
    logic [nlcf_pkg::DEGREE_W-1:0] q_set [NPHASE];
    bit                            tx_pat [NPHASE];
    bit                            rx_pat [NPHASE];

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    sb       = new();
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    q_set  = '{16'd0, 16'hFFFF, 16'($urandom), 16'($urandom_range(0, 50)), 16'd1,
               16'($urandom)};
    tx_pat = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    rx_pat = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // write every table entry once so no need count is ever used unset
    for (k = 0; k < nlcf_pkg::NUM_LABELS_DEF; k++)
      send_word(label_word(nlcf_pkg::ACT_LOAD, nlcf_pkg::LABEL_W'(k), 16'd0, 1'b0));
    run_directed();
    drain();

    // random phases, each setting its query degree and idling pattern from a table
    for (ph = 0; ph < NPHASE; ph++) begin
      write_query_degree(q_set[ph]);
      tx_idle = tx_pat[ph];
      rx_idle = rx_pat[ph];
      phase_start = words_sent;
      clear_needs(1'($urandom));
      repeat ($urandom_range(1, 5))
        load_need(nlcf_pkg::LABEL_W'($urandom),
                  ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20)),
                  1'b0);
      while (words_sent - phase_start < PHASE_WORDS) begin
        if (pool_lbl.size() == 0 && $urandom_range(0, 3) == 0)
          load_need(nlcf_pkg::LABEL_W'($urandom), 16'($urandom_range(1, 20)), 1'b0);
        if ($urandom_range(0, 9) == 0)
          send_noise();
        else
          send_vertex();
      end
      drain();
    end

    $display("Run covered %0d input words under %0d query degrees, 0 and 65535 among them,",
             words_sent, NPHASE);
    $display("checking %0d verdicts, %0d of them accepts.", sb.verdicts, sb.accepts);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
